>>> design/event_task_dispatcher_macros.svh
// ----------------------------------------------------------------------------
// Event task dispatcher assertion macros
// Wrappers for the concurrent checks of the dispatcher; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef EVENT_TASK_DISPATCHER_MACROS_SVH
`define EVENT_TASK_DISPATCHER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside of reset.
`define ETD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define ETD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ETD_ASSERT(lbl, prop, msg)
`define ETD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/etd_pkg.sv
// ----------------------------------------------------------------------------
// Event task dispatcher package
// Item types, request and register codes, control structs and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etd_pkg;

  // Number of pending-event bits held by the block.
  localparam int unsigned NUM_BITS = 32;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned MAX_SLOTS_DEFAULT = 32;

  // Request codes carried by an input item.
  typedef enum logic [1:0] {
    REQ_POST = 2'd0,
    REQ_RR   = 2'd1,
    REQ_PRIO = 2'd2,
    REQ_PASS = 2'd3
  } req_t;

  // Configuration register indexes.
  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_HANDLER    = 1'b1;

  typedef struct packed {
    req_t                req_type;
    logic [NUM_BITS-1:0] event_bits;
  } in_item_t;

  typedef struct packed {
    logic                granted;
    logic [IDX_W-1:0]    slot;
    logic [NUM_BITS-1:0] run_mask;
    logic [CNT_W-1:0]    run_total;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
    logic load_out;
  } etd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_post;
  } etd_stat_t;

  // Mask with the lowest n bits set, n from 0 to NUM_BITS.
  function automatic logic [NUM_BITS-1:0] mask_below(input logic [CNT_W-1:0] n);
    logic [NUM_BITS:0] one_hot;
    one_hot = (NUM_BITS+1)'(1) << n;
    return NUM_BITS'(one_hot - (NUM_BITS+1)'(1));
  endfunction

  // Index of the lowest set bit, 0 when none is set.
  function automatic logic [IDX_W-1:0] lowest_idx(input logic [NUM_BITS-1:0] x);
    logic [NUM_BITS-1:0] iso;
    logic [IDX_W-1:0]    idx;
    iso = x & (~x + NUM_BITS'(1));
    idx = '0;
    for (int i = 0; i < NUM_BITS; i++) begin
      idx = idx | (iso[i] ? IDX_W'(i) : '0);
    end
    return idx;
  endfunction

  // Population count: nibble counts first, then their sum.
  function automatic logic [CNT_W-1:0] pop_count(input logic [NUM_BITS-1:0] x);
    logic [2:0]       nib [NUM_BITS/4];
    logic [CNT_W-1:0] sum;
    for (int i = 0; i < NUM_BITS/4; i++) begin
      nib[i] = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
    end
    sum = '0;
    for (int i = 0; i < NUM_BITS/4; i++) begin
      sum = sum + CNT_W'(nib[i]);
    end
    return sum;
  endfunction

endpackage

>>> design/etd_ctrl.sv
// ----------------------------------------------------------------------------
// Event task dispatcher controller
// Sequences capture, scan and commit of each item and owns the result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  etd_pkg::etd_stat_t stat,
  output etd_pkg::etd_cmd_t  cmd
);
  import etd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   can_commit;
  logic   accept;

  // The result register is free when empty or being drained this cycle.
  assign out_free   = !out_valid_r || !out_stall;
  assign can_commit = (state_r == S_COMMIT) && (stat.is_post || out_free);
  assign in_stall   = !((state_r == S_IDLE) || can_commit);
  assign accept     = in_valid && !in_stall;

  // Commands to the datapath.
  always_comb begin
    cmd.capture  = accept;
    cmd.scan     = (state_r == S_SCAN);
    cmd.commit   = can_commit;
    cmd.load_out = can_commit && !stat.is_post;
  end

  // Next state: an item may enter in the same cycle the previous one commits.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (can_commit) state_nxt = accept ? S_SCAN : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid is set on load and cleared once the item is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/etd_datapath.sv
// ----------------------------------------------------------------------------
// Event task dispatcher datapath
// Holds pending events, pointer and configuration; scans, clears and reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etd_datapath #(
  parameter int unsigned MAX_SLOTS = etd_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  etd_pkg::in_item_t             in_data,
  output etd_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [etd_pkg::NUM_BITS-1:0]  cfg_wdata,
  input  etd_pkg::etd_cmd_t             cmd,
  output etd_pkg::etd_stat_t            stat
);
  import etd_pkg::*;

  localparam int unsigned LIMIT = (MAX_SLOTS < NUM_BITS) ? MAX_SLOTS : NUM_BITS;

  logic [NUM_BITS-1:0] pending_r, pending_nxt;
  logic [IDX_W-1:0]    rr_ptr_r, rr_ptr_nxt;
  logic [CNT_W-1:0]    slot_count_r;
  logic [NUM_BITS-1:0] handler_r;
  req_t                req_r;
  logic [NUM_BITS-1:0] bits_r;
  logic [NUM_BITS-1:0] clr_r, clr_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    found_r, found_nxt;
  out_item_t           out_r, out_nxt;
  logic [CNT_W-1:0]    n_lim;
  logic [NUM_BITS-1:0] valid_bits, ge_mask, part_a, part_b, ah, bh;
  logic [IDX_W-1:0]    fa, fb;
  logic [CNT_W-1:0]    next_slot;
  logic                is_pick;

  // Configuration registers; user must write only while the block is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= CNT_W'(32);
      handler_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOT_COUNT: slot_count_r <= cfg_wdata[CNT_W-1:0];
        REG_HANDLER:    handler_r    <= cfg_wdata;
        default:        handler_r    <= handler_r;
      endcase
    end
  end

  // Effective slot count, saturated at the build limit.
  assign n_lim = (slot_count_r > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : slot_count_r;

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_data.req_type;
      bits_r <= in_data.event_bits;
    end
  end

  assign stat.is_post = (req_r == REQ_POST);
  assign is_pick      = (req_r == REQ_RR) || (req_r == REQ_PRIO);

  // Scan: the round-robin order is the part at or above the pointer, then
  // the part below it. A priority pick sees everything in the first part.
  always_comb begin
    valid_bits = pending_r & mask_below(n_lim);
    ge_mask    = (req_r == REQ_RR) ? ~mask_below(CNT_W'(rr_ptr_r)) : '1;
    part_a     = valid_bits & ge_mask;
    part_b     = valid_bits & ~ge_mask;
    ah         = part_a & handler_r;
    bh         = part_b & handler_r;
    fa         = lowest_idx(ah);
    fb         = lowest_idx(bh);
    hit_nxt    = 1'b0;
    found_nxt  = '0;
    clr_nxt    = valid_bits;
    if (is_pick) begin
      if (ah != '0) begin
        hit_nxt   = 1'b1;
        found_nxt = fa;
        clr_nxt   = part_a & mask_below(CNT_W'(fa) + CNT_W'(1));
      end else if (bh != '0) begin
        hit_nxt   = 1'b1;
        found_nxt = fb;
        clr_nxt   = part_a | (part_b & mask_below(CNT_W'(fb) + CNT_W'(1)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      clr_r   <= clr_nxt;
      hit_r   <= hit_nxt;
      found_r <= found_nxt;
    end
  end

  // Commit: update pending and pointer, build the result.
  assign next_slot = CNT_W'(found_r) + CNT_W'(1);

  always_comb begin
    pending_nxt = pending_r;
    rr_ptr_nxt  = rr_ptr_r;
    if (cmd.commit) begin
      if (stat.is_post) begin
        pending_nxt = pending_r | bits_r;
      end else begin
        pending_nxt = pending_r & ~clr_r;
      end
      if (is_pick && hit_r) begin
        rr_ptr_nxt = (next_slot >= n_lim) ? '0 : next_slot[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      rr_ptr_r  <= '0;
    end else begin
      pending_r <= pending_nxt;
      rr_ptr_r  <= rr_ptr_nxt;
    end
  end

  // Result fields for a pick or a one-pass item.
  always_comb begin
    out_nxt.run_total = pop_count(clr_r);
    if (is_pick) begin
      out_nxt.granted  = hit_r;
      out_nxt.slot     = hit_r ? found_r : '0;
      out_nxt.run_mask = hit_r ? (NUM_BITS'(1) << found_r) : '0;
    end else begin
      out_nxt.granted  = (clr_r != '0);
      out_nxt.slot     = '0;
      out_nxt.run_mask = clr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

>>> design/event_task_dispatcher.sv
// ----------------------------------------------------------------------------
// Event task dispatcher
// Pending-event dispatcher with round-robin and fixed-priority selection.
// ----------------------------------------------------------------------------
// Each item passes through a scan state, which scans the pending mask with
// a rotated priority encode, and a commit state, which commits the new mask
// and pointer and loads the result register. A new item is taken in the
// commit state, so the next item enters while the last one commits; a result
// left waiting in the output register holds the next pick or one-pass item
// in its commit state. Post items give no result. Configuration is always
// ready and must be written only while no item is in flight.
`timescale 1ns / 1ps

module event_task_dispatcher #(
  parameter int unsigned MAX_SLOTS = etd_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  etd_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output etd_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [etd_pkg::NUM_BITS-1:0] cfg_wdata
);
  import etd_pkg::*;

`include "event_task_dispatcher_macros.svh"

  etd_cmd_t  cmd;
  etd_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencing.
  etd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // State, scan and result.
  etd_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  // A result naming a nonzero slot comes from a pick and marks that slot alone.
  `ETD_ASSERT(a_slot_onehot, out_valid && (out_data.slot != '0) |-> $onehot(out_data.run_mask) && out_data.run_mask[out_data.slot], "granted slot does not match run mask")
  // A granted result always handled at least one pending event.
  `ETD_ASSERT(a_grant_count, out_valid && out_data.granted |-> (out_data.run_total != '0), "grant without a handled event")
  // A result that grants nothing reports no slot run.
  `ETD_ASSERT(a_nogrant_mask, out_valid && !out_data.granted |-> (out_data.run_mask == '0) && (out_data.slot == '0), "run mask set without a grant")

endmodule
